@@ rtl/core/f12cw_pkg.sv @@
package f12cw_pkg;

   localparam int TABLE_BYTES_DEFAULT = 8192;
   localparam int TABLE_ADDR_W = 13;
   localparam int CLUSTER_W = 12;
   localparam int LBA_W = 32;
   localparam int SPC_W = 8;
   localparam int CSR_INDEX_W = 1;

   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_ADVANCE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_DATA_START = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CLUS_SECTORS = 1'd1;

   localparam logic [LBA_W-1:0] DATA_START_RESET = 32'd33;
   localparam logic [SPC_W-1:0] SECTORS_RESET = 8'd1;

   localparam logic [CLUSTER_W-1:0] FIRST_DATA_CLUSTER = 12'h002;
   localparam logic [CLUSTER_W-1:0] END_MARK = 12'hff8;
   localparam int ODD_SHIFT = 4;

   typedef struct packed {
      logic [LBA_W-1:0] data_start_lba;
      logic [SPC_W-1:0] clus_sectors;
   } cfg_type;

   typedef struct packed {
      logic                    en;
      logic                    we;
      logic [TABLE_ADDR_W-1:0] addr;
      logic [7:0]              wdata;
   } mem_req_type;

endpackage

@@ rtl/core/f12cw_table.sv @@
module f12cw_table #(
   parameter int TABLE_BYTES = f12cw_pkg::TABLE_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  f12cw_pkg::mem_req_type mem_req,
   output logic [7:0]            rdata
);
   import f12cw_pkg::*;

   localparam int AW = $clog2(TABLE_BYTES);

   logic [7:0] mem [TABLE_BYTES];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.en) begin
         if (mem_req.we) begin
            mem[mem_req.addr[AW-1:0]] <= mem_req.wdata;
         end else begin
            rdata_ff <= mem[mem_req.addr[AW-1:0]];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/f12cw_walk.sv @@
module f12cw_walk #(
   parameter int TABLE_BYTES = f12cw_pkg::TABLE_BYTES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  f12cw_pkg::cfg_type                 cfg,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_func,
   input  logic [f12cw_pkg::TABLE_ADDR_W-1:0] req_table_addr,
   input  logic [7:0]                         req_table_byte,
   input  logic [f12cw_pkg::CLUSTER_W-1:0]    req_start_cluster,
   output f12cw_pkg::mem_req_type             mem_req,
   input  logic [7:0]                         mem_rdata,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [f12cw_pkg::LBA_W-1:0]        rsp_sector_lba,
   output logic [f12cw_pkg::CLUSTER_W-1:0]    rsp_visited_cluster,
   output logic [f12cw_pkg::CLUSTER_W-1:0]    rsp_next_cluster,
   output logic                               rsp_chain_end,
   output logic                               rsp_walk_error
);
   import f12cw_pkg::*;

   localparam int OFS_W = TABLE_ADDR_W + 1;
   localparam logic [OFS_W-1:0] TABLE_LIMIT = OFS_W'(TABLE_BYTES);
   localparam int PROD_W = CLUSTER_W + SPC_W;

   typedef enum logic [1:0] {ST_IDLE, ST_READ_HI, ST_FINISH} state_type;

   state_type                state_ff;
   logic                     live_ff;
   logic [CLUSTER_W-1:0]     cur_ff;
   logic                     err_ff;
   logic [CLUSTER_W-1:0]     vis_ff;
   logic [TABLE_ADDR_W-1:0]  hi_addr_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [LBA_W-1:0]         lba_ff;
   logic [7:0]               lo_ff;
   logic                     rsp_valid_ff;
   logic [LBA_W-1:0]         rsp_lba_ff;
   logic [CLUSTER_W-1:0]     rsp_vis_ff;
   logic [CLUSTER_W-1:0]     rsp_next_ff;
   logic                     rsp_end_ff;
   logic                     rsp_err_ff;

   logic                     accept;
   logic                     is_load;
   logic                     is_visit;
   logic                     load_ok;
   logic [CLUSTER_W-1:0]     cluster;
   logic [OFS_W-1:0]         offset;
   logic [OFS_W-1:0]         offset_hi;
   logic                     visit_err;
   logic [PROD_W-1:0]        prod_in;
   logic [15:0]              pair;
   logic [CLUSTER_W-1:0]     next_in;
   logic                     end_in;
   logic                     out_free;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign is_load  = (req_func == FUNC_LOAD);
   assign is_visit = (req_func == FUNC_START) || (req_func == FUNC_ADVANCE);
   assign load_ok  = {1'b0, req_table_addr} < TABLE_LIMIT;
   assign cluster  = (req_func == FUNC_START) ? req_start_cluster : cur_ff;
   assign offset   = OFS_W'(cluster) + OFS_W'(cluster >> 1);
   assign offset_hi = offset + OFS_W'(1);
   assign visit_err = ((req_func == FUNC_ADVANCE) && !live_ff)
                   || (cluster < FIRST_DATA_CLUSTER) || (offset_hi >= TABLE_LIMIT);
   assign prod_in  = PROD_W'(cluster - FIRST_DATA_CLUSTER) * PROD_W'(cfg.clus_sectors);
   assign pair     = {mem_rdata, lo_ff};
   assign next_in  = vis_ff[0] ? pair[15:ODD_SHIFT] : pair[CLUSTER_W-1:0];
   assign end_in   = next_in >= END_MARK;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      mem_req.en    = 1'b0;
      mem_req.we    = 1'b0;
      mem_req.addr  = offset[TABLE_ADDR_W-1:0];
      mem_req.wdata = req_table_byte;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_load) begin
               mem_req.en   = load_ok;
               mem_req.we   = 1'b1;
               mem_req.addr = req_table_addr;
            end else if (accept && is_visit) begin
               mem_req.en = !visit_err;
            end
         end
         ST_READ_HI: begin
            mem_req.en   = 1'b1;
            mem_req.addr = hi_addr_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= 1'b0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && is_visit) begin
                  err_ff     <= visit_err;
                  vis_ff     <= cluster;
                  hi_addr_ff <= offset_hi[TABLE_ADDR_W-1:0];
                  prod_ff    <= prod_in;
                  state_ff   <= visit_err ? ST_FINISH : ST_READ_HI;
               end
            end
            ST_READ_HI: begin
               lo_ff    <= mem_rdata;
               lba_ff   <= cfg.data_start_lba + LBA_W'(prod_ff);
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_vis_ff   <= vis_ff;
                  rsp_err_ff   <= err_ff;
                  if (err_ff) begin
                     rsp_lba_ff  <= '0;
                     rsp_next_ff <= '0;
                     rsp_end_ff  <= 1'b0;
                     live_ff     <= 1'b0;
                  end else begin
                     rsp_lba_ff  <= lba_ff;
                     rsp_next_ff <= next_in;
                     rsp_end_ff  <= end_in;
                     cur_ff      <= next_in;
                     live_ff     <= !end_in;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sector_lba      = rsp_lba_ff;
   assign rsp_visited_cluster = rsp_vis_ff;
   assign rsp_next_cluster    = rsp_next_ff;
   assign rsp_chain_end       = rsp_end_ff;
   assign rsp_walk_error      = rsp_err_ff;

endmodule

@@ rtl/core/fat12_cluster_chain_walker.sv @@
// FAT12 cluster chain walker.
// Request channel (req_*): valid/stall. func 0 writes one allocation table byte,
// func 1 starts a chain at req_start_cluster, func 2 advances to the stored next
// cluster; func 3 is dropped. Only funcs 1 and 2 produce a response transaction.
// Response channel (rsp_*): first sector LBA, visited and next cluster, end and
// error flags, held in an output register until taken.
// Config (csr_*): index 0 data start LBA, index 1 sectors per cluster; write
// only while no request is in flight.
// Sequence: a load writes its byte (if in range) on accept. A start or advance
// reads the single-port table (low entry byte on accept, high in ST_READ_HI),
// and ST_FINISH registers the result and rsp_valid; a refused visit skips the reads.
// While the block is busy req_stall is high. A result waits in the finish step
// while an earlier response is stalled, and req_stall stays high meanwhile.
// Reset (synchronous) clears the chain state and the response valid and sets
// the config registers to 33 and 1; table contents are undefined until loaded.
module fat12_cluster_chain_walker #(
   parameter int TABLE_BYTES = f12cw_pkg::TABLE_BYTES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_func,
   input  logic [f12cw_pkg::TABLE_ADDR_W-1:0]  req_table_addr,
   input  logic [7:0]                          req_table_byte,
   input  logic [f12cw_pkg::CLUSTER_W-1:0]     req_start_cluster,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [f12cw_pkg::LBA_W-1:0]         rsp_sector_lba,
   output logic [f12cw_pkg::CLUSTER_W-1:0]     rsp_visited_cluster,
   output logic [f12cw_pkg::CLUSTER_W-1:0]     rsp_next_cluster,
   output logic                                rsp_chain_end,
   output logic                                rsp_walk_error,
   input  logic                                csr_write_enable,
   input  logic [f12cw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [f12cw_pkg::LBA_W-1:0]         csr_write_data
);
   import f12cw_pkg::*;

   cfg_type     cfg_ff;
   mem_req_type mem_req;
   logic [7:0]  mem_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.data_start_lba <= DATA_START_RESET;
         cfg_ff.clus_sectors   <= SECTORS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_DATA_START:   cfg_ff.data_start_lba <= csr_write_data;
            REG_CLUS_SECTORS: cfg_ff.clus_sectors   <= csr_write_data[SPC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   f12cw_table #(
      .TABLE_BYTES(TABLE_BYTES)
   ) u_table (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   f12cw_walk #(
      .TABLE_BYTES(TABLE_BYTES)
   ) u_walk (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_table_addr      (req_table_addr),
      .req_table_byte      (req_table_byte),
      .req_start_cluster   (req_start_cluster),
      .mem_req             (mem_req),
      .mem_rdata           (mem_rdata),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_sector_lba      (rsp_sector_lba),
      .rsp_visited_cluster (rsp_visited_cluster),
      .rsp_next_cluster    (rsp_next_cluster),
      .rsp_chain_end       (rsp_chain_end),
      .rsp_walk_error      (rsp_walk_error)
   );

endmodule
